[rtl/spq_pkg.sv]
// Shared widths, register indexes and pipeline sideband types for the sphere point query.
`default_nettype none
package spq_pkg;
  localparam int COORD_W = 32;
  localparam int MAG_W   = COORD_W + 1;
  localparam int SQR_W   = 2 * MAG_W;
  localparam int SUM_W   = SQR_W + 1;
  localparam int ROOT_W  = 34;
  localparam int RAD_W   = 31;
  localparam int TOL_W   = 16;
  localparam int DIST_W  = 34;
  localparam int DIFF_W  = ROOT_W + 1;
  localparam int PROD_W  = MAG_W + RAD_W;
  localparam int QUO_W   = RAD_W;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;
  localparam int AXES    = 3;

  localparam logic [IDX_W-1:0] REG_CENTER_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_CENTER_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CENTER_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_RADIUS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_RIM_TOL   = 3'd4;

  // carried alongside the square root
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] p;
    logic [AXES-1:0]              neg;
    logic [AXES-1:0][MAG_W-1:0]   mag;
    logic                         chk;
  } sq_tag_t;

  // carried alongside the divider
  typedef struct packed {
    logic [AXES-1:0][COORD_W-1:0] p;
    logic [AXES-1:0]              neg;
    logic                         sel_p;
    logic [DIST_W-1:0]            sdist;
    logic                         is_in;
  } dv_tag_t;
endpackage
`default_nettype wire

[rtl/spq_if.sv]
// Valid/ready channel interfaces for query points and query results.
`default_nettype none
interface spq_in_if import spq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [COORD_W-1:0] point_z;
  logic               check_rim;
  modport source (output valid, point_x, point_y, point_z, check_rim, input ready);
  modport sink (input valid, point_x, point_y, point_z, check_rim, output ready);
endinterface

interface spq_out_if import spq_pkg::*;;
  logic               valid;
  logic               ready;
  logic [DIST_W-1:0]  signed_distance;
  logic [COORD_W-1:0] closest_x;
  logic [COORD_W-1:0] closest_y;
  logic [COORD_W-1:0] closest_z;
  logic               is_inside;
  modport source (output valid, signed_distance, closest_x, closest_y, closest_z, is_inside,
                  input ready);
  modport sink (input valid, signed_distance, closest_x, closest_y, closest_z, is_inside,
                output ready);
endinterface
`default_nettype wire

[rtl/spq_sqrt.sv]
// Pipelined floor square root, one result bit per stage.
`default_nettype none
module spq_sqrt import spq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              ce,
  input  wire logic              in_valid,
  input  wire logic [SUM_W-1:0]  n,
  input  wire sq_tag_t           in_tag,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      root,
  output sq_tag_t                out_tag
);
  logic              v    [ROOT_W];
  logic [SUM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] rt   [ROOT_W];
  sq_tag_t           tg   [ROOT_W];

  genvar k;
  for (k = 0; k < ROOT_W; k++) begin : g_st
    localparam int B = ROOT_W - 1 - k;
    logic              sv;
    logic [SUM_W-1:0]  srem;
    logic [ROOT_W-1:0] sroot;
    sq_tag_t           stag;
    logic [SUM_W:0]    trial;
    logic              take;

    if (k == 0) begin : g_first
      assign sv    = in_valid;
      assign srem  = n;
      assign sroot = '0;
      assign stag  = in_tag;
    end else begin : g_next
      assign sv    = v[k-1];
      assign srem  = rem[k-1];
      assign sroot = rt[k-1];
      assign stag  = tg[k-1];
    end

    // remainder holds n - root^2; test (2*root + 2^B) * 2^B against it
    assign trial = ({{(SUM_W+1-ROOT_W){1'b0}}, sroot} << (B + 1))
                 | ((SUM_W+1)'(1) << (2 * B));
    assign take  = {1'b0, srem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (ce) begin
        v[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k] <= take ? (srem - trial[SUM_W-1:0]) : srem;
        rt[k]  <= take ? (sroot | (ROOT_W'(1) << B)) : sroot;
        tg[k]  <= stag;
      end
    end
  end

  assign out_valid = v[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign out_tag   = tg[ROOT_W-1];
endmodule
`default_nettype wire

[rtl/spq_div.sv]
// Pipelined restoring divider for three axes sharing one divisor, one quotient bit per stage.
`default_nettype none
module spq_div import spq_pkg::*; (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         ce,
  input  wire logic                         in_valid,
  input  wire logic [AXES-1:0][PROD_W-1:0]  num,
  input  wire logic [ROOT_W-1:0]            den,
  input  wire dv_tag_t                      in_tag,
  output logic                              out_valid,
  output logic [AXES-1:0][QUO_W-1:0]        quo,
  output dv_tag_t                           out_tag
);
  logic                        v   [QUO_W];
  logic [AXES-1:0][PROD_W-1:0] rem [QUO_W];
  logic [AXES-1:0][QUO_W-1:0]  q   [QUO_W];
  logic [ROOT_W-1:0]           dn  [QUO_W];
  dv_tag_t                     tg  [QUO_W];

  genvar k, a;
  for (k = 0; k < QUO_W; k++) begin : g_st
    localparam int B = QUO_W - 1 - k;
    logic                        sv;
    logic [AXES-1:0][PROD_W-1:0] srem;
    logic [AXES-1:0][QUO_W-1:0]  sq;
    logic [ROOT_W-1:0]           sden;
    dv_tag_t                     stag;
    logic [PROD_W:0]             dsh;
    logic [AXES-1:0][PROD_W-1:0] nrem;
    logic [AXES-1:0][QUO_W-1:0]  nq;

    if (k == 0) begin : g_first
      assign sv   = in_valid;
      assign srem = num;
      assign sq   = '0;
      assign sden = den;
      assign stag = in_tag;
    end else begin : g_next
      assign sv   = v[k-1];
      assign srem = rem[k-1];
      assign sq   = q[k-1];
      assign sden = dn[k-1];
      assign stag = tg[k-1];
    end

    assign dsh = {{(PROD_W+1-ROOT_W){1'b0}}, sden} << B;

    // quotient is known to stay below 2^QUO_W, so the top bit starts here
    for (a = 0; a < AXES; a++) begin : g_ax
      always_comb begin
        if ({1'b0, srem[a]} >= dsh) begin
          nrem[a] = srem[a] - dsh[PROD_W-1:0];
          nq[a]   = sq[a] | (QUO_W'(1) << B);
        end else begin
          nrem[a] = srem[a];
          nq[a]   = sq[a];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (ce) begin
        v[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem[k] <= nrem;
        q[k]   <= nq;
        dn[k]  <= sden;
        tg[k]  <= stag;
      end
    end
  end

  assign out_valid = v[QUO_W-1];
  assign quo       = q[QUO_W-1];
  assign out_tag   = tg[QUO_W-1];
endmodule
`default_nettype wire

[rtl/sphere_point_query.sv]
// Top level: closest point on a sphere and signed distance for a stream of query points.
//
//  channel   dir   carries
//  in_pt     in    point_x, point_y, point_z, check_rim
//  out_res   out   signed_distance, closest_x/y/z, is_inside
//  cfg_*     in    center_x/y/z, radius, rim_tolerance writes
//
// One point per cycle while the output is not stalled; stages: difference, square, sum, 34 root stages,
// product, 31 divider stages, output register.
// The whole pipeline advances when the output register is empty or being taken.
// Synchronous reset clears all valid bits and loads the register defaults.
`default_nettype none
module sphere_point_query import spq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_write,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  spq_in_if.sink                in_pt,
  spq_out_if.source             out_res
);
  logic [AXES-1:0][COORD_W-1:0] center;
  logic [RAD_W-1:0]             radius;
  logic [TOL_W-1:0]             rim_tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      center        <= '0;
      radius        <= '0;
      rim_tolerance <= TOL_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CENTER_X: center[0]     <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y: center[1]     <= cfg_data[COORD_W-1:0];
        REG_CENTER_Z: center[2]     <= cfg_data[COORD_W-1:0];
        REG_RADIUS:   radius        <= cfg_data[RAD_W-1:0];
        REG_RIM_TOL:  rim_tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic ce;
  logic ov;
  assign ce          = !ov || out_res.ready;
  assign in_pt.ready = ce;

  // stage 1: difference and magnitude
  logic                         v1;
  sq_tag_t                      t1;
  logic [AXES-1:0][COORD_W-1:0] pin;
  logic [AXES-1:0][MAG_W-1:0]   dif;
  sq_tag_t                      t1_next;

  assign pin = {in_pt.point_z, in_pt.point_y, in_pt.point_x};

  always_comb begin
    t1_next     = '0;
    t1_next.p   = pin;
    t1_next.chk = in_pt.check_rim;
    for (int a = 0; a < AXES; a++) begin
      dif[a]         = {pin[a][COORD_W-1], pin[a]} - {center[a][COORD_W-1], center[a]};
      t1_next.neg[a] = dif[a][MAG_W-1];
      t1_next.mag[a] = dif[a][MAG_W-1] ? (MAG_W'(0) - dif[a]) : dif[a];
    end
  end

  // stage 2: squares
  logic                       v2;
  sq_tag_t                    t2;
  logic [AXES-1:0][SQR_W-1:0] sqr;

  // stage 3: sum of squares
  logic             v3;
  sq_tag_t          t3;
  logic [SUM_W-1:0] sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (ce) begin
      v1 <= in_pt.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t1 <= t1_next;
      for (int a = 0; a < AXES; a++) begin
        sqr[a] <= t1.mag[a] * t1.mag[a];
      end
      t2  <= t1;
      sum <= SUM_W'(sqr[0]) + SUM_W'(sqr[1]) + SUM_W'(sqr[2]);
      t3  <= t2;
    end
  end

  logic              vr;
  logic [ROOT_W-1:0] len;
  sq_tag_t           tr;

  spq_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v3),
    .n         (sum),
    .in_tag    (t3),
    .out_valid (vr),
    .root      (len),
    .out_tag   (tr)
  );

  // stage after the root: products, distance, selection
  logic                        vp;
  logic [AXES-1:0][PROD_W-1:0] prod;
  logic [ROOT_W-1:0]           lp;
  dv_tag_t                     tp;
  dv_tag_t                     tp_next;
  logic [DIFF_W-1:0]           dwide;
  logic [DIFF_W-1:0]           thr;

  always_comb begin
    dwide          = {1'b0, len} - DIFF_W'(radius);
    thr            = tr.chk ? DIFF_W'(rim_tolerance) : '0;
    tp_next        = '0;
    tp_next.p      = tr.p;
    tp_next.neg    = tr.neg;
    tp_next.sel_p  = (len < ROOT_W'(radius)) || (len == '0);
    tp_next.is_in  = $signed(dwide) < $signed(thr);
    if (dwide[DIFF_W-1] != dwide[DIFF_W-2]) begin
      tp_next.sdist = dwide[DIFF_W-1] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
    end else begin
      tp_next.sdist = dwide[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (ce) begin
      vp <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int a = 0; a < AXES; a++) begin
        prod[a] <= tr.mag[a] * radius;
      end
      lp <= len;
      tp <= tp_next;
    end
  end

  logic                       vd;
  logic [AXES-1:0][QUO_W-1:0] quo;
  dv_tag_t                    td;

  spq_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (vp),
    .num       (prod),
    .den       (lp),
    .in_tag    (tp),
    .out_valid (vd),
    .quo       (quo),
    .out_tag   (td)
  );

  // output register: closest point with saturation
  logic [AXES-1:0][MAG_W-1:0]   csum;
  logic [AXES-1:0][COORD_W-1:0] cp_next;
  logic [AXES-1:0][COORD_W-1:0] cp;
  logic [DIST_W-1:0]            dist_q;
  logic                         inside_q;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      csum[a] = {center[a][COORD_W-1], center[a]}
              + (td.neg[a] ? (MAG_W'(0) - MAG_W'(quo[a])) : MAG_W'(quo[a]));
      if (td.sel_p) begin
        cp_next[a] = td.p[a];
      end else if (csum[a][MAG_W-1] != csum[a][COORD_W-1]) begin
        cp_next[a] = csum[a][MAG_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                      : {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
        cp_next[a] = csum[a][COORD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (ce) begin
      ov <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cp       <= cp_next;
      dist_q   <= td.sdist;
      inside_q <= td.is_in;
    end
  end

  assign out_res.valid           = ov;
  assign out_res.signed_distance = dist_q;
  assign out_res.closest_x       = cp[0];
  assign out_res.closest_y       = cp[1];
  assign out_res.closest_z       = cp[2];
  assign out_res.is_inside       = inside_q;

  // a negative distance is always below the threshold
  a_neg_inside: assert property (@(posedge clk) disable iff (rst)
    out_res.valid && out_res.signed_distance[DIST_W-1] |-> out_res.is_inside)
    else $error("negative distance not flagged inside");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_res.valid)
    else $error("result valid after reset");

  // point at center with nonzero radius must return the point itself
  a_center_sel: assert property (@(posedge clk) disable iff (rst)
    vp && (lp == '0) |-> tp.sel_p)
    else $error("zero length did not select the point");
endmodule
`default_nettype wire
